// File: hw/rtl/vfs_pkg.sv
`default_nettype none

package vfs_pkg;

  // Fixed-point fraction bits of every position, aim and step.
  localparam int FRAC_BITS = 4;

  localparam int POS_W  = 17;
  localparam int CFG_W  = 12;
  localparam int DIVR_W = 8;
  localparam int REQ_W  = 3;
  localparam int IDX_W  = 3;
  localparam int IN_W   = 16;
  localparam int SPR_W  = 8;
  // Distance to target before division, and corner plus step.
  localparam int DIF_W  = 19;
  localparam int SUM_W  = 21;
  localparam int MAG_W  = DIF_W - 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] VEL_MIN = POS_MIN + POS_W'(1);

  localparam int HALF_LSB = (1 << FRAC_BITS) >> 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK         = 3'd0,
    REQ_GOTO_SMOOTH  = 3'd1,
    REQ_GOTO_INSTANT = 3'd2,
    REQ_LOCK         = 3'd3,
    REQ_RELEASE      = 3'd4
  } req_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_VIEW_W  = 3'd0,
    CFG_VIEW_H  = 3'd1,
    CFG_ROOM_W  = 3'd2,
    CFG_ROOM_H  = 3'd3,
    CFG_DIVISOR = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    if (v < SUM_W'(POS_MIN)) return POS_MIN;
    if (v > SUM_W'(POS_MAX)) return POS_MAX;
    return POS_W'(v);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
    if (v < SUM_W'(VEL_MIN)) return VEL_MIN;
    if (v > SUM_W'(POS_MAX)) return POS_MAX;
    return POS_W'(v);
  endfunction

  // Round to whole pixels, halves away from zero.
  function automatic logic signed [DIF_W-1:0] round_px(input logic signed [DIF_W-1:0] v);
    logic [DIF_W-1:0] mag;
    logic [DIF_W-1:0] r;
    mag = v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
    r   = (mag + DIF_W'(HALF_LSB)) >> FRAC_BITS;
    return v[DIF_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/viewport_follow_scroller.sv
`default_nettype none

// Viewport follow scroller: moves a view's top-left corner toward a target.
// Input channel (in_valid/in_ready) carries one request per transaction:
// a tick, a smooth or instant go-to, a lock or a release, with a position
// and the tracked sprite's size. Every input transaction yields exactly one
// output transaction (out_valid/out_ready) carrying the corner, the step of
// the last tick and the mode flags after that request.
// A tick works through the X axis and then the Y axis on one shared
// arithmetic path and one shared restoring divider, which produces one
// quotient bit per cycle. One request is in progress at a time and
// in_ready is high only while the sequencer is idle, so a new request is
// accepted only after the previous result has been loaded. The result sits
// in an output register; if the receiver stalls, the sequencer holds the
// finished result and accepts nothing until the register is free.
// Reset (rst, synchronous) puts the view at the origin, clears steps and
// aims, selects follow mode and loads the default register values. The
// user is to write the configuration port (cfg_we, cfg_index, cfg_data)
// only while idle; the block itself does not enforce this.
module viewport_follow_scroller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [vfs_pkg::REQ_W-1:0]   req_type,
  input  logic        [vfs_pkg::IN_W-1:0]    pos_x,
  input  logic        [vfs_pkg::IN_W-1:0]    pos_y,
  input  logic        [vfs_pkg::SPR_W-1:0]   follow_w,
  input  logic        [vfs_pkg::SPR_W-1:0]   follow_h,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vfs_pkg::POS_W-1:0]   view_x,
  output logic signed [vfs_pkg::POS_W-1:0]   view_y,
  output logic signed [vfs_pkg::POS_W-1:0]   vel_x,
  output logic signed [vfs_pkg::POS_W-1:0]   vel_y,
  output logic                               manual_on,
  output logic                               coming_back,
  input  logic                               cfg_we,
  input  logic        [vfs_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [vfs_pkg::CFG_W-1:0]   cfg_data
);
  import vfs_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]  view_width;
  logic [CFG_W-1:0]  view_height;
  logic [CFG_W-1:0]  room_width;
  logic [CFG_W-1:0]  room_height;
  logic [DIVR_W-1:0] approach_divisor;

  // Architectural state.
  logic signed [POS_W-1:0] view_left;
  logic signed [POS_W-1:0] view_top;
  logic signed [POS_W-1:0] step_x;
  logic signed [POS_W-1:0] step_y;
  logic signed [POS_W-1:0] aim_x;
  logic signed [POS_W-1:0] aim_y;
  logic                    manual_flag;
  logic                    return_flag;

  // Sequencer working registers.
  state_t state;
  state_t state_next;
  logic   ax;
  logic   clamp_mode;
  logic   snap_r;
  logic   rawz_x;

  logic accept;
  logic div_start;
  logic out_load;

  logic signed [POS_W-1:0] sel_pos;
  logic signed [POS_W-1:0] sel_aim;
  logic [CFG_W-1:0]        sel_view;
  logic [CFG_W-1:0]        sel_room;
  logic [DIVR_W-1:0]       div_eff;

  logic signed [POS_W-1:0] u_aim;
  logic                    u_snap;
  logic signed [DIF_W-1:0] u_diff;
  logic signed [POS_W-1:0] u_pos;
  logic signed [POS_W-1:0] u_step;
  logic                    u_rawz;

  logic signed [DIF_W-1:0] div_quot;
  div_stat_t               div_stat;

  logic signed [SUM_W-1:0] follow_ax;
  logic signed [SUM_W-1:0] follow_ay;
  logic signed [SUM_W-1:0] goto_lx;
  logic signed [SUM_W-1:0] goto_ty;

  assign in_ready  = state == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign div_start = state == ST_PREP;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    sel_pos  = ax ? view_top : view_left;
    sel_aim  = ax ? aim_y : aim_x;
    sel_view = ax ? view_height : view_width;
    sel_room = ax ? room_height : room_width;
    // A divisor of zero behaves as one.
    div_eff  = (approach_divisor == '0) ? DIVR_W'(1) : approach_divisor;

    follow_ax = SUM_W'(pos_x) + $signed(SUM_W'(follow_w >> 1) << FRAC_BITS);
    follow_ay = SUM_W'(pos_y) + $signed(SUM_W'(follow_h >> 1) << FRAC_BITS);
    goto_lx   = SUM_W'(pos_x) - $signed(SUM_W'(view_width >> 1) << FRAC_BITS);
    goto_ty   = SUM_W'(pos_y) - $signed(SUM_W'(view_height >> 1) << FRAC_BITS);
  end

  vfs_axis u_axis (
    .pos       (sel_pos),
    .aim       (sel_aim),
    .clamp_aim (clamp_mode),
    .view_px   (sel_view),
    .room_px   (sel_room),
    .snap_hold (snap_r),
    .quot      (div_quot),
    .aim_new   (u_aim),
    .snap      (u_snap),
    .diff      (u_diff),
    .pos_new   (u_pos),
    .step_new  (u_step),
    .raw_zero  (u_rawz)
  );

  vfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (u_diff),
    .divisor  (div_eff),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_TICK) ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ax ? ST_DONE : ST_PREP;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width       <= CFG_W'(320);
      view_height      <= CFG_W'(240);
      room_width       <= CFG_W'(320);
      room_height      <= CFG_W'(240);
      approach_divisor <= DIVR_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIEW_W:  view_width       <= cfg_data;
        CFG_VIEW_H:  view_height      <= cfg_data;
        CFG_ROOM_W:  room_width       <= cfg_data;
        CFG_ROOM_H:  room_height      <= cfg_data;
        CFG_DIVISOR: approach_divisor <= cfg_data[DIVR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request handling and the per-axis tick steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      view_left   <= '0;
      view_top    <= '0;
      step_x      <= '0;
      step_y      <= '0;
      aim_x       <= '0;
      aim_y       <= '0;
      manual_flag <= 1'b0;
      return_flag <= 1'b0;
      ax          <= 1'b0;
      clamp_mode  <= 1'b0;
      snap_r      <= 1'b0;
      rawz_x      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_t'(req_type))
              REQ_TICK: begin
                // In follow mode the target is the sprite's centre.
                if (!manual_flag) begin
                  aim_x <= sat_pos(follow_ax);
                  aim_y <= sat_pos(follow_ay);
                end
                clamp_mode <= manual_flag || return_flag;
                ax         <= 1'b0;
              end
              REQ_GOTO_SMOOTH: begin
                manual_flag <= 1'b1;
                aim_x       <= POS_W'(pos_x);
                aim_y       <= POS_W'(pos_y);
              end
              REQ_GOTO_INSTANT: begin
                manual_flag <= 1'b1;
                aim_x       <= POS_W'(pos_x);
                aim_y       <= POS_W'(pos_y);
                view_left   <= sat_pos(goto_lx);
                view_top    <= sat_pos(goto_ty);
              end
              REQ_LOCK: begin
                manual_flag <= 1'b1;
              end
              REQ_RELEASE: begin
                manual_flag <= 1'b0;
                return_flag <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PREP: begin
          snap_r <= u_snap;
          if (ax) begin
            aim_y <= u_aim;
          end else begin
            aim_x <= u_aim;
          end
        end
        ST_FIN: begin
          if (ax) begin
            view_top <= u_pos;
            step_y   <= u_step;
            // Returning ends once neither axis needed a step this tick.
            if (rawz_x && u_rawz) begin
              return_flag <= 1'b0;
            end
          end else begin
            view_left <= u_pos;
            step_x    <= u_step;
            rawz_x    <= u_rawz;
            ax        <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      view_x      <= view_left;
      view_y      <= view_top;
      vel_x       <= step_x;
      vel_y       <= step_y;
      manual_on   <= manual_flag;
      coming_back <= return_flag;
    end
  end

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  // A division is never started on top of one still running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // Finishing the second axis always leads to the result stage.
  a_y_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && ax) |=> state == ST_DONE)
    else $error("tick did not complete after the second axis");

  // Return mode is entered only by an accepted release request.
  a_return_by_release: assert property (@(posedge clk) disable iff (rst)
    $rose(return_flag) |-> $past(accept && req_type == REQ_RELEASE))
    else $error("return mode set without a release request");

endmodule

`default_nettype wire

// File: hw/rtl/vfs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, truncating toward zero.
module vfs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [vfs_pkg::DIF_W-1:0]  dividend,
  input  logic        [vfs_pkg::DIVR_W-1:0] divisor,
  output logic signed [vfs_pkg::DIF_W-1:0]  quotient,
  output vfs_pkg::div_stat_t                stat
);
  import vfs_pkg::*;

  logic [MAG_W-1:0]  quo;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic              busy;
  logic              done;

  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_diff;
  logic              take;
  logic [DIF_W-1:0]  mag_in;

  always_comb begin
    rem_sh   = {rem, quo[MAG_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    take     = rem_sh >= {1'b0, dvs};
    mag_in   = dividend[DIF_W-1] ? DIF_W'(-dividend) : DIF_W'(dividend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag_in[MAG_W-1:0];
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[DIF_W-1];
    end else if (busy) begin
      quo <= {quo[MAG_W-2:0], take};
      rem <= take ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
    end
  end

  assign quotient  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: hw/rtl/vfs_axis.sv
`default_nettype none

// Per-axis arithmetic, shared by both axes. The preparation outputs clamp the
// aim, test for a snap and form the distance to divide; the finishing outputs
// apply the quotient and clamp the corner to the room.
module vfs_axis (
  input  logic signed [vfs_pkg::POS_W-1:0] pos,
  input  logic signed [vfs_pkg::POS_W-1:0] aim,
  input  logic                             clamp_aim,
  input  logic        [vfs_pkg::CFG_W-1:0] view_px,
  input  logic        [vfs_pkg::CFG_W-1:0] room_px,
  input  logic                             snap_hold,
  input  logic signed [vfs_pkg::DIF_W-1:0] quot,
  output logic signed [vfs_pkg::POS_W-1:0] aim_new,
  output logic                             snap,
  output logic signed [vfs_pkg::DIF_W-1:0] diff,
  output logic signed [vfs_pkg::POS_W-1:0] pos_new,
  output logic signed [vfs_pkg::POS_W-1:0] step_new,
  output logic                             raw_zero
);
  import vfs_pkg::*;

  logic signed [SUM_W-1:0] half;
  logic signed [SUM_W-1:0] room;
  logic signed [SUM_W-1:0] bound;
  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] p_ext;
  logic signed [SUM_W-1:0] a_cl;
  logic signed [SUM_W-1:0] a_new_ext;
  logic signed [SUM_W-1:0] p_base;
  logic signed [SUM_W-1:0] s_raw;
  logic signed [SUM_W-1:0] p_sum;
  logic signed [SUM_W-1:0] p_cl;
  logic signed [SUM_W-1:0] s_cl;

  always_comb begin
    half  = $signed(SUM_W'(view_px >> 1) << FRAC_BITS);
    room  = $signed(SUM_W'(room_px) << FRAC_BITS);
    bound = room - $signed(SUM_W'(view_px) << FRAC_BITS);
    a_ext = SUM_W'(aim);
    p_ext = SUM_W'(pos);

    // In clamp mode, keep the centre target inside the room, high side tested first.
    a_cl = a_ext;
    if (clamp_aim) begin
      if (a_ext + half > room) begin
        a_cl = room - half;
      end else if (a_ext < half) begin
        a_cl = half;
      end
    end
    aim_new   = sat_pos(a_cl);
    a_new_ext = SUM_W'(aim_new);

    snap = round_px(DIF_W'(p_ext + half)) == round_px(DIF_W'(a_new_ext));
    diff = DIF_W'(a_new_ext - half - p_ext);

    // Finishing: the stored aim is already clamped at this point.
    p_base = snap_hold ? a_ext - half : p_ext;
    s_raw  = snap_hold ? '0 : SUM_W'(quot);
    p_sum  = p_base + s_raw;
    if (p_sum < 0) begin
      p_cl = '0;
      s_cl = '0;
    end else if (p_sum > bound) begin
      p_cl = bound;
      s_cl = '0;
    end else begin
      p_cl = p_sum;
      s_cl = s_raw;
    end
    pos_new  = sat_pos(p_cl);
    step_new = sat_vel(s_cl);
    raw_zero = s_raw == '0;
  end

endmodule

`default_nettype wire
